// ===== hdl/sdbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbp_pkg
// Shared constants and types of the sparse delta block packer.
// ----------------------------------------------------------------------------
package sdbp_pkg;

  localparam int MAX_OPS     = 1024;
  localparam int BLOCK_SIZE  = 64;
  localparam int BLK_COUNT   = (MAX_OPS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int LANES       = 8;
  localparam int ROWS        = MAX_OPS / LANES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int LANE_W      = $clog2(LANES);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  // value width codes: width = 1 << code
  localparam logic [2:0] W1  = 3'd0;
  localparam logic [2:0] W2  = 3'd1;
  localparam logic [2:0] W4  = 3'd2;
  localparam logic [2:0] W8  = 3'd3;
  localparam logic [2:0] W16 = 3'd4;
  localparam logic [2:0] W32 = 3'd5;

  typedef struct packed {
    logic        valid;
    logic        is_val;
    logic [2:0]  wcode;
    logic [2:0]  lane;
    logic [1:0]  sub;
    logic [7:0]  lane_ok;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
  } meta_t;

endpackage

// ===== hdl/sdbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbp_if
// Request, result and configuration channels of the packer.
// ----------------------------------------------------------------------------
interface sdbp_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [30:0] cost;
  logic [30:0] baseline_cost;
  logic        last_op;
  modport source (output valid, req_type, cost, baseline_cost, last_op, input ready);
  modport sink (input valid, req_type, cost, baseline_cost, last_op, output ready);
endinterface

interface sdbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blob_byte;
  logic       byte_last;
  logic [1:0] status;
  modport source (output valid, blob_byte, byte_last, status, input ready);
  modport sink (input valid, blob_byte, byte_last, status, output ready);
endinterface

interface sdbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/sdbp_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbp_vram
// Value store: rows of eight 32-bit lanes, lane write, registered row read.
// ----------------------------------------------------------------------------
module sdbp_vram (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           we,
  input  logic [sdbp_pkg::ROW_W-1:0]     waddr,
  input  logic [sdbp_pkg::LANE_W-1:0]    wlane,
  input  logic [31:0]                    wdata,
  input  logic [sdbp_pkg::ROW_W-1:0]     raddr,
  output logic [sdbp_pkg::LANES-1:0][31:0] rdata
);

  logic [sdbp_pkg::LANES-1:0][31:0] mem [sdbp_pkg::ROWS];
  logic [sdbp_pkg::LANES-1:0][31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane] <= wdata;
    end
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sdbp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbp_ctrl
// Request register, vector state, block closing and blob address decode.
// ----------------------------------------------------------------------------
module sdbp_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  sdbp_in_if.sink                           in_if,
  sdbp_cfg_if.sink                          cfg_if,
  output logic                              mem_we,
  output logic [sdbp_pkg::ROW_W-1:0]        mem_waddr,
  output logic [sdbp_pkg::LANE_W-1:0]       mem_wlane,
  output logic [31:0]                       mem_wdata,
  output logic [sdbp_pkg::ROW_W-1:0]        mem_raddr,
  output sdbp_pkg::meta_t                   meta
);

  typedef enum logic [1:0] {PH_LOAD, PH_READY, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        s1_v_r;
  logic        s1_req_r;
  logic [30:0] s1_cost_r;
  logic [30:0] s1_base_r;
  logic        s1_last_r;
  logic [30:0] inf_r;
  logic [10:0] opc_r, opc_nxt;
  logic [10:0] dvc_r, dvc_nxt;
  logic [4:0]  dbc_r, dbc_nxt;
  logic [15:0] map_r, map_nxt;
  logic [63:0] cmask_r, cmask_nxt;
  logic [31:0] max_r, max_nxt;
  logic [12:0] rp_r, rp_nxt;
  logic        drop_r, drop_nxt;
  logic [63:0] mstore_r [sdbp_pkg::BLK_COUNT];
  logic        mstore_we;

  logic        go;
  logic [10:0] opc_e, dvc_e;
  logic [4:0]  dbc_e;
  logic [15:0] map_e;
  logic [63:0] cmask_e, mask_n;
  logic [31:0] max_e, val;
  logic        drop_e, diff, closing;
  logic [5:0]  bitlen;
  logic [2:0]  wcode;
  logic [4:0]  blocks;
  logic [1:0]  bm;
  logic [2:0]  mo;
  logic [7:0]  vo;
  logic [12:0] vb, total, q, qm;
  logic [6:0]  row;
  logic [9:0]  gidx;

  function automatic logic [12:0] clr_rp(phase_t ph, logic [12:0] rp);
    return (ph != PH_LOAD) ? 13'd0 : rp;
  endfunction

  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;
  assign go = s1_v_r && adv;

  always_comb begin
    bitlen = '0;
    for (int i = 0; i < 32; i++) begin
      if (max_r[i]) bitlen = 6'(i + 1);
    end
    if (bitlen <= 6'd1)       wcode = sdbp_pkg::W1;
    else if (bitlen == 6'd2)  wcode = sdbp_pkg::W2;
    else if (bitlen <= 6'd4)  wcode = sdbp_pkg::W4;
    else if (bitlen <= 6'd8)  wcode = sdbp_pkg::W8;
    else if (bitlen <= 6'd16) wcode = sdbp_pkg::W16;
    else                      wcode = sdbp_pkg::W32;
  end

  always_comb begin
    blocks = 5'((opc_r + 11'd63) >> 6);
    bm     = 2'((blocks + 5'd7) >> 3);
    mo     = 3'd1 + {1'b0, bm};
    vo     = {5'd0, mo} + {dbc_r, 3'd0};
    unique case (wcode)
      sdbp_pkg::W1:  vb = 13'((dvc_r + 11'd7) >> 3);
      sdbp_pkg::W2:  vb = 13'((dvc_r + 11'd3) >> 2);
      sdbp_pkg::W4:  vb = 13'((dvc_r + 11'd1) >> 1);
      sdbp_pkg::W8:  vb = {2'd0, dvc_r};
      sdbp_pkg::W16: vb = {1'b0, dvc_r, 1'b0};
      default:       vb = {dvc_r, 2'd0};
    endcase
    total = {5'd0, vo} + vb;
    q     = rp_r - {5'd0, vo};
    qm    = rp_r - {10'd0, mo};
    unique case (wcode)
      sdbp_pkg::W1:  row = q[6:0];
      sdbp_pkg::W2:  row = q[7:1];
      sdbp_pkg::W4:  row = q[8:2];
      sdbp_pkg::W8:  row = q[9:3];
      sdbp_pkg::W16: row = q[10:4];
      default:       row = q[11:5];
    endcase
  end

  always_comb begin
    clr_check: begin
      logic clr;
      clr     = (phase_r != PH_LOAD);
      opc_e   = clr ? '0 : opc_r;
      dvc_e   = clr ? '0 : dvc_r;
      dbc_e   = clr ? '0 : dbc_r;
      map_e   = clr ? '0 : map_r;
      cmask_e = clr ? '0 : cmask_r;
      max_e   = clr ? '0 : max_r;
      drop_e  = clr ? 1'b0 : drop_r;
    end
    diff    = (s1_cost_r != s1_base_r);
    val     = (s1_cost_r == inf_r) ? 32'd0 : {1'b0, s1_cost_r} + 32'd1;
    mask_n  = cmask_e | ({63'd0, diff} << opc_e[5:0]);
    closing = (opc_e[5:0] == 6'd63) || (opc_e == 11'(sdbp_pkg::MAX_OPS - 1)) || s1_last_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    dvc_nxt   = dvc_r;
    dbc_nxt   = dbc_r;
    map_nxt   = map_r;
    cmask_nxt = cmask_r;
    max_nxt   = max_r;
    rp_nxt    = rp_r;
    drop_nxt  = drop_r;
    mem_we    = 1'b0;
    mstore_we = 1'b0;
    mem_waddr = dvc_e[9:3];
    mem_wlane = dvc_e[2:0];
    mem_wdata = val;
    mem_raddr = row;
    gidx      = '0;
    meta      = '0;
    meta.wcode = wcode;
    if (go && s1_req_r == sdbp_pkg::REQ_PUSH) begin
      phase_nxt = PH_LOAD;
      opc_nxt   = opc_e;
      dvc_nxt   = dvc_e;
      dbc_nxt   = dbc_e;
      map_nxt   = map_e;
      cmask_nxt = cmask_e;
      max_nxt   = max_e;
      drop_nxt  = drop_e;
      rp_nxt    = clr_rp(phase_r, rp_r);
      if (opc_e >= 11'(sdbp_pkg::MAX_OPS)) begin
        drop_nxt = 1'b1;
      end else begin
        if (diff) begin
          mem_we  = 1'b1;
          dvc_nxt = dvc_e + 11'd1;
          if (val > max_e) max_nxt = val;
        end
        cmask_nxt = mask_n;
        opc_nxt   = opc_e + 11'd1;
        if (closing) begin
          if (mask_n != '0 && dbc_e < 5'(sdbp_pkg::BLK_COUNT)) begin
            map_nxt[opc_e[9:6]] = 1'b1;
            mstore_we = 1'b1;
            dbc_nxt   = dbc_e + 5'd1;
          end
          cmask_nxt = '0;
        end
      end
      if (s1_last_r) begin
        phase_nxt = PH_READY;
        rp_nxt    = '0;
      end
    end else if (go) begin
      meta.valid = 1'b1;
      if (phase_r != PH_READY) begin
        meta.status = sdbp_pkg::ST_NONE;
      end else begin
        meta.status = drop_r ? sdbp_pkg::ST_DROP : sdbp_pkg::ST_OK;
        meta.last   = ({1'b0, rp_r} + 14'd1) >= {1'b0, total};
        rp_nxt      = rp_r + 13'd1;
        if (meta.last) phase_nxt = PH_DONE;
        if (rp_r == '0) begin
          meta.data = 8'd1 << wcode;
        end else if (rp_r < {10'd0, mo}) begin
          meta.data = rp_r[0] ? map_r[7:0] : map_r[15:8];
        end else if (rp_r < {5'd0, vo}) begin
          meta.data = mstore_r[qm[6:3]][{qm[2:0], 3'd0} +: 8];
        end else begin
          meta.is_val = 1'b1;
          for (int k = 0; k < 8; k++) begin
            gidx = {row, 3'(k)};
            meta.lane_ok[k] = ({1'b0, gidx} < dvc_r);
          end
          unique case (wcode)
            sdbp_pkg::W1:  meta.sub = 2'd0;
            sdbp_pkg::W2:  meta.sub = {1'b0, q[0]};
            sdbp_pkg::W4:  meta.sub = q[1:0];
            sdbp_pkg::W8:  meta.sub = 2'd0;
            sdbp_pkg::W16: meta.sub = {1'b0, q[0]};
            default:       meta.sub = q[1:0];
          endcase
          unique case (wcode)
            sdbp_pkg::W8:  meta.lane = q[2:0];
            sdbp_pkg::W16: meta.lane = q[3:1];
            sdbp_pkg::W32: meta.lane = q[4:2];
            default:       meta.lane = 3'd0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      phase_r <= PH_LOAD;
      inf_r   <= 31'h7FFF_FFFF;
      opc_r   <= '0;
      dvc_r   <= '0;
      dbc_r   <= '0;
      map_r   <= '0;
      cmask_r <= '0;
      max_r   <= '0;
      rp_r    <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (adv) s1_v_r <= in_if.valid;
      if (cfg_if.valid) inf_r <= cfg_if.data;
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      dvc_r   <= dvc_nxt;
      dbc_r   <= dbc_nxt;
      map_r   <= map_nxt;
      cmask_r <= cmask_nxt;
      max_r   <= max_nxt;
      rp_r    <= rp_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_if.valid) begin
      s1_req_r  <= in_if.req_type;
      s1_cost_r <= in_if.cost;
      s1_base_r <= in_if.baseline_cost;
      s1_last_r <= in_if.last_op;
    end
    if (mstore_we) begin
      mstore_r[dbc_e[3:0]] <= mask_n;
    end
  end

endmodule

// ===== hdl/sdbp_fmt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbp_fmt
// Byte assembly from the value row and result register.
// ----------------------------------------------------------------------------
module sdbp_fmt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sdbp_pkg::meta_t                    meta,
  input  logic [sdbp_pkg::LANES-1:0][31:0]   rdata,
  output logic                               adv,
  sdbp_out_if.source                         out_if
);

  sdbp_pkg::meta_t meta_r;
  logic            out_v_r;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [1:0]      status_r;
  logic [7:0]      vbyte;
  logic [2:0]      li;
  logic [31:0]     lw;

  assign adv = !out_v_r || out_if.ready;

  always_comb begin
    vbyte = '0;
    li    = '0;
    lw    = rdata[meta_r.lane];
    unique case (meta_r.wcode)
      sdbp_pkg::W1: begin
        for (int k = 0; k < 8; k++) begin
          vbyte[k] = rdata[k][0] & meta_r.lane_ok[k];
        end
      end
      sdbp_pkg::W2: begin
        for (int k = 0; k < 4; k++) begin
          li = {meta_r.sub[0], 2'(k)};
          vbyte[2*k +: 2] = meta_r.lane_ok[li] ? rdata[li][1:0] : 2'd0;
        end
      end
      sdbp_pkg::W4: begin
        for (int k = 0; k < 2; k++) begin
          li = {meta_r.sub, 1'(k)};
          vbyte[4*k +: 4] = meta_r.lane_ok[li] ? rdata[li][3:0] : 4'd0;
        end
      end
      sdbp_pkg::W8:  vbyte = lw[7:0];
      sdbp_pkg::W16: vbyte = lw[{meta_r.sub[0], 3'd0} +: 8];
      default:       vbyte = lw[{meta_r.sub, 3'd0} +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
      out_v_r      <= 1'b0;
    end else if (adv) begin
      meta_r  <= meta;
      out_v_r <= meta_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r   <= meta_r.is_val ? vbyte : meta_r.data;
      last_r   <= meta_r.last;
      status_r <= meta_r.status;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.blob_byte = byte_r;
  assign out_if.byte_last = last_r;
  assign out_if.status    = status_r;

endmodule

// ===== hdl/sparse_delta_block_packer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_delta_block_packer_core
// Sparse delta encoder with bitmap, block masks and packed values.
// A read request's byte passes the request, metadata/row and result registers.
// Throughput: one request per cycle unless stalled; the row read sets the depth.
// Pushes give no result. A full result register held by the sink stalls all.
// Reset (rst_n, synchronous): empty vector, loading, infinite code 0x7FFFFFFF.
// ----------------------------------------------------------------------------
module sparse_delta_block_packer_core (
  input  logic         clk,
  input  logic         rst_n,
  sdbp_in_if.sink      in_if,
  sdbp_out_if.source   out_if,
  sdbp_cfg_if.sink     cfg_if
);

  logic                                adv;
  logic                                mem_we;
  logic [sdbp_pkg::ROW_W-1:0]          mem_waddr;
  logic [sdbp_pkg::LANE_W-1:0]         mem_wlane;
  logic [31:0]                         mem_wdata;
  logic [sdbp_pkg::ROW_W-1:0]          mem_raddr;
  logic [sdbp_pkg::LANES-1:0][31:0]    mem_rdata;
  sdbp_pkg::meta_t                     meta;

  sdbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wlane (mem_wlane),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .meta      (meta)
  );

  sdbp_vram u_vram (
    .clk   (clk),
    .en    (adv),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wlane (mem_wlane),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sdbp_fmt u_fmt (
    .clk    (clk),
    .rst_n  (rst_n),
    .meta   (meta),
    .rdata  (mem_rdata),
    .adv    (adv),
    .out_if (out_if)
  );

endmodule

// ===== bench/sparse_delta_block_packer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_delta_block_packer_core_tb
// Self-checking bench for the sparse delta block packer. Cost vectors are
// pushed and their blobs read back byte by byte. A predictor kept in step
// with accepted requests builds the expected bytes, which are compared in
// order with the result channel. Both sides idle at random, the receiver
// also holds off once for a long stretch, and the infinite code is moved
// between vectors.
// ----------------------------------------------------------------------------
module sparse_delta_block_packer_core_tb;

  typedef enum logic [1:0] {VEC_LOADING, VEC_READY, VEC_DONE} vec_phase_t;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       byte_last;
    logic [1:0] status;
  } blob_rsp_t;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;

  sdbp_in_if  in_if ();
  sdbp_out_if out_if ();
  sdbp_cfg_if cfg_if ();

  sparse_delta_block_packer_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // packer state as predicted
  logic [31:0] vstore [sdbp_pkg::MAX_OPS];
  logic [63:0] mstore [sdbp_pkg::BLK_COUNT];
  logic [sdbp_pkg::BLK_COUNT-1:0] dmap;
  logic [63:0] cmask;
  int unsigned nops, nvals, nblks, rpos;
  logic [31:0] vmax;
  logic        dropped;
  vec_phase_t  vec_phase;
  logic [30:0] inf_code;

  blob_rsp_t expected_bytes[$];
  int mismatches;
  int pushes, reads, bytes_seen, vectors, cfg_writes;
  bit idle_en;
  int hold_req;
  int quiet_cycles;

  task automatic clear_vector();
    dmap = '0;
    cmask = '0;
    nops = 0;
    nvals = 0;
    nblks = 0;
    vmax = '0;
    vec_phase = VEC_LOADING;
    rpos = 0;
    dropped = 1'b0;
  endtask

  task automatic close_block(input int unsigned blk);
    if (cmask != 0 && blk < sdbp_pkg::BLK_COUNT && nblks < sdbp_pkg::BLK_COUNT) begin
      dmap[blk] = 1'b1;
      mstore[nblks] = cmask;
      nblks++;
    end
    cmask = '0;
  endtask

  task automatic model_push(input logic [30:0] c, input logic [30:0] b, input logic lo);
    int unsigned i;
    logic [31:0] v;
    if (vec_phase != VEC_LOADING) clear_vector();
    if (nops >= sdbp_pkg::MAX_OPS) begin
      dropped = 1'b1;
    end else begin
      i = nops;
      if (c != b) begin
        v = (c == inf_code) ? 32'd0 : {1'b0, c} + 32'd1;
        cmask[i % sdbp_pkg::BLOCK_SIZE] = 1'b1;
        vstore[nvals] = v;
        nvals++;
        if (v > vmax) vmax = v;
      end
      nops++;
      if (i % sdbp_pkg::BLOCK_SIZE == sdbp_pkg::BLOCK_SIZE - 1 ||
          i == sdbp_pkg::MAX_OPS - 1 || lo)
        close_block(i / sdbp_pkg::BLOCK_SIZE);
    end
    if (lo) begin
      vec_phase = VEC_READY;
      rpos = 0;
    end
  endtask

  function automatic int unsigned packed_width();
    int unsigned w, p;
    logic [31:0] v;
    w = 0;
    p = 1;
    v = vmax;
    while (v != 0) begin
      w++;
      v = v >> 1;
    end
    while (p < w) p = p << 1;
    return p;
  endfunction

  function automatic logic [7:0] blob_byte_at(input int unsigned p, input int unsigned bits,
                                              input int unsigned bm);
    int unsigned mo, vo, q, per, idx, nb;
    logic [31:0] acc;
    mo = 1 + bm;
    vo = mo + 8 * nblks;
    if (p == 0) return bits[7:0];
    if (p < mo) return dmap[8 * (p - 1) +: 8];
    if (p < vo) begin
      q = p - mo;
      return mstore[q / 8][(q % 8) * 8 +: 8];
    end
    q = p - vo;
    if (bits < 8) begin
      per = 8 / bits;
      acc = '0;
      for (int k = 0; k < per; k++) begin
        idx = q * per + k;
        if (idx < nvals) acc = acc | (vstore[idx] << (k * bits));
      end
      return acc[7:0];
    end
    nb = bits / 8;
    idx = q / nb;
    return vstore[idx][(q % nb) * 8 +: 8];
  endfunction

  task automatic model_read();
    int unsigned blocks, bm, bits, total, vbytes;
    blob_rsp_t r;
    if (vec_phase != VEC_READY) begin
      r = '{blob_byte: 8'd0, byte_last: 1'b0, status: sdbp_pkg::ST_NONE};
    end else begin
      blocks = (nops + sdbp_pkg::BLOCK_SIZE - 1) / sdbp_pkg::BLOCK_SIZE;
      bm = (blocks + 7) / 8;
      bits = packed_width();
      vbytes = (bits < 8) ? (nvals + 8 / bits - 1) / (8 / bits) : nvals * (bits / 8);
      total = 1 + bm + 8 * nblks + vbytes;
      r.blob_byte = blob_byte_at(rpos, bits, bm);
      r.byte_last = (rpos + 1 >= total);
      r.status = dropped ? sdbp_pkg::ST_DROP : sdbp_pkg::ST_OK;
      rpos++;
      if (r.byte_last) vec_phase = VEC_DONE;
    end
    expected_bytes = {expected_bytes, r};
  endtask

  task automatic send_req(input logic rt, input logic [30:0] c, input logic [30:0] b,
                          input logic lo);
    int gap;
    gap = idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= rt;
    in_if.cost <= c;
    in_if.baseline_cost <= b;
    in_if.last_op <= lo;
    do @(posedge clk); while (!in_if.ready);
    if (rt == sdbp_pkg::REQ_PUSH) begin
      model_push(c, b, lo);
      pushes++;
    end else begin
      model_read();
      reads++;
    end
  endtask

  task automatic push_op(input logic [30:0] c, input logic [30:0] b, input logic lo);
    send_req(sdbp_pkg::REQ_PUSH, c, b, lo);
  endtask

  task automatic read_byte();
    send_req(sdbp_pkg::REQ_READ, 31'($urandom), 31'($urandom), 1'($urandom));
  endtask

  task automatic drain_blob();
    while (vec_phase == VEC_READY) read_byte();
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_inf_code(input logic [30:0] v);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    inf_code = v;
    cfg_writes++;
  endtask

  // cost below 2^k or inf_code; baseline equal at most (100 - pct_dirty)%
  task automatic random_op(input int k, input int pct_dirty, input logic lo);
    logic [30:0] c, b;
    c = (k >= 31) ? 31'($urandom) : 31'($urandom & ((32'd1 << k) - 1));
    if ($urandom_range(0, 19) == 0) c = inf_code;
    b = ($urandom_range(0, 99) < pct_dirty) ? 31'($urandom) : c;
    if ($urandom_range(0, 9) == 0) b = c ^ 31'(1 << $urandom_range(0, 30));
    push_op(c, b, lo);
  endtask

  task automatic test_directed();
    read_byte();
    push_op(31'd0, 31'd0, 1'b0);
    push_op(31'd0, 31'h7FFF_FFFF, 1'b0);
    push_op(31'h7FFF_FFFE, 31'd0, 1'b0);
    push_op(31'h7FFF_FFFF, 31'd5, 1'b0);
    push_op(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    push_op(31'd1, 31'd2, 1'b0);
    read_byte();
    push_op(31'h5555_5555, 31'h2AAA_AAAA, 1'b1);
    drain_blob();
    read_byte();
    push_op(31'd0, 31'd1, 1'b1);
    read_byte();
    push_op(31'd3, 31'd3, 1'b1);
    drain_blob();
    read_byte();
    vectors += 3;
  endtask

  task automatic test_infinite_code();
    logic [30:0] codes [3];
    codes = '{31'd0, 31'h7FFF_FFFF, 31'($urandom)};
    foreach (codes[n]) begin
      write_inf_code(codes[n]);
      push_op(codes[n], codes[n] ^ 31'd1, 1'b0);
      push_op(31'd0, 31'd9, 1'b0);
      push_op(31'h7FFF_FFFF, 31'd0, 1'b0);
      push_op(codes[n], 31'd7, 1'b1);
      drain_blob();
      vectors++;
    end
  endtask

  task automatic test_block_widths();
    for (int k = 0; k <= 31; k += 6) begin
      for (int i = 0; i < 6; i++) random_op(k, 40, i == 5);
      drain_blob();
      vectors++;
    end
  endtask

  task automatic test_capacity();
    logic [30:0] c;
    logic        dirty;
    idle_en = 1'b0;
    for (int i = 0; i < sdbp_pkg::MAX_OPS + 2; i++) begin
      c = 31'($urandom_range(0, 3));
      dirty = (i % 300 == 0) || (i >= sdbp_pkg::MAX_OPS - 1);
      push_op(c, dirty ? (c ^ 31'd1) : c, i == sdbp_pkg::MAX_OPS + 1);
    end
    drain_blob();
    read_byte();
    idle_en = 1'b1;
    vectors++;
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 300;
    for (int i = 0; i < 12; i++) random_op(8, 80, i == 11);
    drain_blob();
    repeat (6) read_byte();
    idle_en = 1'b1;
    vectors++;
  endtask

  task automatic test_random();
    int len, k, pct, nrd;
    while (pushes + reads < 350) begin
      if ($urandom_range(0, 9) == 0) write_inf_code(31'($urandom));
      idle_en = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(1, 3);
        1, 2, 3: len = $urandom_range(64, 100);
        default: len = $urandom_range(1, 40);
      endcase
      k = $urandom_range(0, 31);
      pct = $urandom_range(0, 100);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 29) == 0) read_byte();
        random_op(k, pct, i == len - 1);
      end
      if ($urandom_range(0, 6) == 0) begin
        nrd = $urandom_range(0, 6);
        repeat (nrd) read_byte();
      end else begin
        drain_blob();
        if ($urandom_range(0, 3) == 0) read_byte();
      end
      vectors++;
    end
  endtask

  // result side
  initial begin
    int n;
    blob_rsp_t exp_r, got;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = idle_en ? $urandom_range(0, 6) : 0;
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = '{blob_byte: out_if.blob_byte, byte_last: out_if.byte_last, status: out_if.status};
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        exp_r = expected_bytes.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b status %0d, got byte %h last %b status %0d",
                     exp_r.blob_byte, exp_r.byte_last, exp_r.status,
                     got.blob_byte, got.byte_last, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sparse_delta_block_packer_core_tb: errors");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    mismatches = 0;
    pushes = 0;
    reads = 0;
    bytes_seen = 0;
    vectors = 0;
    cfg_writes = 0;
    hold_req = 0;
    idle_en = 1'b1;
    inf_code = 31'h7FFF_FFFF;
    clear_vector();
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.req_type <= sdbp_pkg::REQ_PUSH;
    in_if.cost <= '0;
    in_if.baseline_cost <= '0;
    in_if.last_op <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_infinite_code();
    test_block_widths();
    test_backpressure();
    test_random();
    test_capacity();
    settle();

    $display("covered %0d vectors: %0d pushes, %0d reads, %0d bytes checked, %0d code writes",
             vectors, pushes, reads, bytes_seen, cfg_writes);
    $display("includes over-capacity vectors and a long receiver hold-off");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("sparse_delta_block_packer_core_tb: clean");
    end else begin
      $display("sparse_delta_block_packer_core_tb: errors");
    end
    $finish;
  end

endmodule
